[rtl/fixed_block_free_list_allocator_macros.svh]
// ----------------------------------------------------------------------------
// Free list allocator assertion macros
// Concurrent assertion helpers shared by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle.
`define FBFL_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define FBFL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FBFL_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define FBFL_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

[rtl/fbfl_pkg.sv]
// ----------------------------------------------------------------------------
// Free list allocator package
// Sizes, operation and status codes, and the result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fbfl_pkg;

  localparam int CHUNKS = 256;
  localparam int IDX_W  = $clog2(CHUNKS);
  // A link holds a chunk index or the end marker CHUNKS.
  localparam int LINK_W = IDX_W + 1;
  localparam int CFG_W  = 9;

  localparam logic [LINK_W-1:0] END_MARK = LINK_W'(CHUNKS);

  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_FREE    = 2'd1;
  localparam logic [1:0] KIND_REBUILD = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] index;
  } res_t;

endpackage

[rtl/fixed_block_free_list_allocator.sv]
// ----------------------------------------------------------------------------
// Fixed block free list allocator
// Pool of equal chunks kept as a linked free list in a link memory.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  s       | in        | s_tvalid/s_tready  | tuser: kind, tdata: chunk_index
//  m       | out       | m_tvalid/m_tready  | tuser: status, tdata: granted_index
//  cfg     | in        | cfg_valid/cfg_ready| cfg_data: chunk_count
//
// A free, a rejected request, a no-op and an allocate on an empty pool finish
// in the cycle of acceptance; an allocate that pops reads the link memory on
// acceptance and pushes its result from ST_ALLOC. A rebuild writes one link
// per cycle and then pushes its result. The input is held off while an
// allocate or a rebuild runs. Results go to a two-entry output queue, so a new
// transaction is taken while one result waits. Reset empties the list and the
// queue and sets the count to 256; the link memory is not cleared.
`timescale 1ns / 1ps
`include "fixed_block_free_list_allocator_macros.svh"

module fixed_block_free_list_allocator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,   // [7:0] chunk_index
  input  logic [1:0]                   s_tuser,   // [1:0] kind
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [7:0]                   m_tdata,   // [7:0] granted_index
  output logic [1:0]                   m_tuser,   // [1:0] status
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [fbfl_pkg::CFG_W-1:0]   cfg_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ALLOC = 2'd1;
  localparam logic [1:0] ST_BUILD = 2'd2;

  logic [1:0]                   state;
  logic [1:0]                   state_next;
  logic [fbfl_pkg::LINK_W-1:0]  head;
  logic [fbfl_pkg::LINK_W-1:0]  head_next;
  logic [fbfl_pkg::CFG_W-1:0]   chunk_count;
  logic [fbfl_pkg::LINK_W-1:0]  build_idx;
  logic [fbfl_pkg::LINK_W-1:0]  build_idx_next;
  logic [fbfl_pkg::LINK_W-1:0]  build_n;
  logic [fbfl_pkg::LINK_W-1:0]  eff_count;

  logic [fbfl_pkg::LINK_W-1:0]  link_mem [fbfl_pkg::CHUNKS];
  logic [fbfl_pkg::LINK_W-1:0]  rd_data;
  logic                         rd_en;
  logic                         wr_en;
  logic [fbfl_pkg::IDX_W-1:0]   wr_addr;
  logic [fbfl_pkg::LINK_W-1:0]  wr_data;

  fbfl_pkg::res_t               q0, q1, q0_next, q1_next, push_res;
  logic [1:0]                   res_cnt, res_cnt_next, cnt_after_pop;
  logic                         push, pop, accept;
  logic [1:0]                   kind;
  logic [fbfl_pkg::IDX_W-1:0]   idx;

  assign kind     = s_tuser;
  assign idx      = s_tdata[fbfl_pkg::IDX_W-1:0];
  assign cfg_ready = 1'b1;

  // One item in flight; the queue must keep a slot for its result.
  assign s_tready = (state == ST_IDLE) && (res_cnt != 2'd2);
  assign accept   = s_tvalid && s_tready;

  assign eff_count = (chunk_count > fbfl_pkg::CFG_W'(fbfl_pkg::CHUNKS)) ?
                     fbfl_pkg::END_MARK : fbfl_pkg::LINK_W'(chunk_count);

  always_comb begin
    state_next     = state;
    head_next      = head;
    build_idx_next = build_idx;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = idx;
    wr_data        = head;
    push           = 1'b0;
    push_res       = '{status: fbfl_pkg::STATUS_OK, index: '0};
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (kind)
            fbfl_pkg::KIND_ALLOC: begin
              if (head[fbfl_pkg::IDX_W]) begin
                push            = 1'b1;
                push_res.status = fbfl_pkg::STATUS_EMPTY;
              end else begin
                rd_en      = 1'b1;
                state_next = ST_ALLOC;
              end
            end
            fbfl_pkg::KIND_FREE: begin
              push = 1'b1;
              if (fbfl_pkg::LINK_W'(idx) < eff_count) begin
                wr_en     = 1'b1;
                head_next = fbfl_pkg::LINK_W'(idx);
              end else begin
                push_res.status = fbfl_pkg::STATUS_RANGE;
              end
            end
            fbfl_pkg::KIND_REBUILD: begin
              head_next      = fbfl_pkg::END_MARK;
              build_idx_next = '0;
              state_next     = ST_BUILD;
            end
            default: begin
              push = 1'b1;
            end
          endcase
        end
      end
      ST_ALLOC: begin
        push           = 1'b1;
        push_res.index = head[fbfl_pkg::IDX_W-1:0];
        head_next      = rd_data;
        state_next     = ST_IDLE;
      end
      ST_BUILD: begin
        if (build_idx == build_n) begin
          push       = 1'b1;
          state_next = ST_IDLE;
        end else begin
          // Push chunk build_idx: its link is the current head.
          wr_en          = 1'b1;
          wr_addr        = build_idx[fbfl_pkg::IDX_W-1:0];
          head_next      = build_idx;
          build_idx_next = build_idx + 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= link_mem[head[fbfl_pkg::IDX_W-1:0]];
    end
  end

  // Two-entry result queue, q0 at the output.
  assign pop           = m_tvalid && m_tready;
  assign cnt_after_pop = res_cnt - {1'b0, pop};

  always_comb begin
    q0_next      = pop ? q1 : q0;
    q1_next      = q1;
    res_cnt_next = cnt_after_pop + {1'b0, push};
    if (push) begin
      if (cnt_after_pop == 2'd0) begin
        q0_next = push_res;
      end else begin
        q1_next = push_res;
      end
    end
  end

  assign m_tvalid = (res_cnt != 2'd0);
  assign m_tuser  = q0.status;
  assign m_tdata  = 8'(q0.index);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      head        <= fbfl_pkg::END_MARK;
      chunk_count <= fbfl_pkg::CFG_W'(256);
      res_cnt     <= 2'd0;
      build_idx   <= '0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      res_cnt   <= res_cnt_next;
      build_idx <= build_idx_next;
      if (cfg_valid && cfg_ready) begin
        chunk_count <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    q0 <= q0_next;
    q1 <= q1_next;
    if (accept) begin
      build_n <= eff_count;
    end
  end

  `FBFL_ASSERT_NEXT(a_alloc_reads, clk, rst,
    accept && kind == fbfl_pkg::KIND_ALLOC && !head[fbfl_pkg::IDX_W],
    state == ST_ALLOC, "allocate with free chunks did not enter the read cycle")
  `FBFL_ASSERT_SAME(a_alloc_room, clk, rst, state == ST_ALLOC,
    res_cnt != 2'd2, "no queue slot for an allocate result")
  `FBFL_ASSERT_SAME(a_build_bound, clk, rst, state == ST_BUILD,
    build_idx <= build_n, "rebuild ran past the chunk count")
  `FBFL_ASSERT_SAME(a_head_marker, clk, rst, head[fbfl_pkg::IDX_W],
    head[fbfl_pkg::IDX_W-1:0] == '0, "list head holds an invalid link")

endmodule
